FILE: hw/rtl/hgs_pkg.sv
// Shared types and constants for the hash guarded stack.
package hgs_pkg;

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_CHECK = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RSVD  = 2'd3
	} status_t;

	localparam int unsigned NEWTON_STEPS = 6;
	localparam logic [63:0] NEWTON_TWO = 64'd2;

endpackage

FILE: hw/rtl/hgs_mul64.sv
// Multi-cycle 64x64 multiplier, low 64 bits of the product, one 32x32 product a cycle.
module hgs_mul64 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] p
);

	logic [63:0] a_q, b_q, prod_q, acc_q;
	logic [1:0]  cnt_q;
	logic        active_q;
	logic [31:0] ma, mb;
	logic [63:0] full;

	// Pick the partial product for this cycle
	always_comb begin
		unique case (cnt_q)
			2'd0: begin ma = a_q[31:0];  mb = b_q[31:0]; end
			2'd1: begin ma = a_q[31:0];  mb = b_q[63:32]; end
			default: begin ma = a_q[63:32]; mb = b_q[31:0]; end
		endcase
		full = 64'(ma) * 64'(mb);
	end

	// Sequence the partial products and accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= 2'd0;
			done     <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				active_q <= 1'b1;
				cnt_q    <= 2'd0;
			end else if (active_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					active_q <= 1'b0;
					done     <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			a_q    <= a;
			b_q    <= b;
			prod_q <= 64'd0;
			acc_q  <= 64'd0;
		end else if (active_q) begin
			if (cnt_q == 2'd0)
				prod_q <= full;
			else
				prod_q <= {full[31:0], 32'd0};
			acc_q <= acc_q + prod_q;
			if (cnt_q == 2'd3)
				p <= acc_q + prod_q;
		end
	end

endmodule

FILE: hw/rtl/hgs_store.sv
// Element memory: one write port, one registered read port.
module hgs_store #(
	parameter int DW    = 32,
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata_q
);

	logic [DW-1:0] mem [DEPTH];

	// Write and read; read data holds until the next read
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata_q <= mem[raddr];
	end

endmodule

FILE: hw/rtl/hash_guarded_stack.sv
// Top level: LIFO stack with a rolling 64-bit polynomial hash.
// Push and pop each wait for one multiply, then register the result; full push,
// empty pop and op 3 register it at the accepting edge; a check hashes each stored element.
// Throughput is set by the shared multi-cycle 64-bit multiplier and the single read port of the memory.
// A base write busies the block for 6 Newton steps of two multiplies.
// Reset clears count and hash and sets inverse and base to 1; element memory is not cleared.
module hash_guarded_stack #(
	parameter int DEPTH      = 1024,
	parameter int ELEM_WIDTH = 32,
	localparam int CW = $clog2(DEPTH + 1),
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  logic [1:0]    op,
	input  logic [31:0]   push_value,
	input  logic          cfg_we,
	input  logic [63:0]   cfg_data,
	output logic          done,
	output logic [1:0]    status,
	output logic [31:0]   top_value,
	output logic [CW-1:0] depth_now,
	output logic          hash_ok,
	output logic [63:0]   hash_value
);

	typedef enum logic [3:0] {
		S_IDLE, S_INV_A, S_INV_B, S_PUSH, S_POP,
		S_CHK_RD, S_CHK_WAIT, S_CHK_MUL
	} state_t;

	state_t              state_q;
	logic [63:0]         base_q, inv_q, hash_q, h_q;
	logic [CW-1:0]       count_q, idx_q;
	logic [ELEM_WIDTH-1:0] top_q, val_q;
	logic [2:0]          step_q;
	logic                mul_go_q, mul_done;
	logic [63:0]         mul_a_q, mul_b_q, mul_p;
	logic                mem_we, mem_re;
	logic [AW-1:0]       mem_waddr, mem_raddr;
	logic [ELEM_WIDTH-1:0] mem_rdata;
	logic [CW-1:0]       cnt_m2;

	hgs_mul64 u_mul (
		.clk(clk), .arst_n(arst_n), .go(mul_go_q), .a(mul_a_q), .b(mul_b_q),
		.done(mul_done), .p(mul_p)
	);

	hgs_store #(.DW(ELEM_WIDTH), .DEPTH(DEPTH), .AW(AW)) u_store (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(ELEM_WIDTH'(push_value)),
		.re(mem_re), .raddr(mem_raddr), .rdata_q(mem_rdata)
	);

	assign busy   = (state_q != S_IDLE);
	assign cnt_m2 = count_q - CW'(2);

	// Memory port: push writes at start, pop fetches the new top, check walks up
	always_comb begin
		mem_we    = start && !busy && (hgs_pkg::op_t'(op) == hgs_pkg::OP_PUSH)
		            && (count_q != CW'(DEPTH));
		mem_waddr = count_q[AW-1:0];
		mem_re    = 1'b0;
		mem_raddr = idx_q[AW-1:0];
		if (start && !busy && (hgs_pkg::op_t'(op) == hgs_pkg::OP_POP)) begin
			mem_re    = (count_q >= CW'(2));
			mem_raddr = cnt_m2[AW-1:0];
		end else if (state_q == S_CHK_RD && idx_q != count_q) begin
			mem_re = 1'b1;
		end
	end

	// Control sequencer with registered results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			base_q     <= 64'd1;
			inv_q      <= 64'd1;
			hash_q     <= 64'd0;
			h_q        <= 64'd0;
			count_q    <= '0;
			top_q      <= '0;
			val_q      <= '0;
			done       <= 1'b0;
			status     <= hgs_pkg::ST_OK;
			top_value  <= 32'd0;
			depth_now  <= '0;
			hash_ok    <= 1'b0;
			hash_value <= 64'd0;
			mul_go_q   <= 1'b0;
			mul_a_q    <= 64'd0;
			mul_b_q    <= 64'd0;
			step_q     <= 3'd0;
			idx_q      <= '0;
		end else begin
			done     <= 1'b0;
			mul_go_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cfg_we) begin
						base_q   <= cfg_data | 64'd1;
						inv_q    <= 64'd1;
						step_q   <= 3'd0;
						mul_a_q  <= cfg_data | 64'd1;
						mul_b_q  <= 64'd1;
						mul_go_q <= 1'b1;
						state_q  <= S_INV_A;
					end else if (start) begin
						priority case (hgs_pkg::op_t'(op))
							hgs_pkg::OP_PUSH: begin
								if (count_q == CW'(DEPTH)) begin
									done       <= 1'b1;
									status     <= hgs_pkg::ST_FULL;
									top_value  <= 32'(top_q);
									depth_now  <= count_q;
									hash_ok    <= 1'b0;
									hash_value <= hash_q;
								end else begin
									val_q    <= ELEM_WIDTH'(push_value);
									mul_a_q  <= hash_q;
									mul_b_q  <= base_q;
									mul_go_q <= 1'b1;
									state_q  <= S_PUSH;
								end
							end
							hgs_pkg::OP_POP: begin
								if (count_q == '0) begin
									done       <= 1'b1;
									status     <= hgs_pkg::ST_EMPTY;
									top_value  <= 32'd0;
									depth_now  <= count_q;
									hash_ok    <= 1'b0;
									hash_value <= hash_q;
								end else begin
									mul_a_q  <= hash_q - 64'(top_q);
									mul_b_q  <= inv_q;
									mul_go_q <= 1'b1;
									state_q  <= S_POP;
								end
							end
							hgs_pkg::OP_CHECK: begin
								idx_q   <= '0;
								h_q     <= 64'd0;
								state_q <= S_CHK_RD;
							end
							default: begin
								done       <= 1'b1;
								status     <= hgs_pkg::ST_OK;
								top_value  <= 32'(top_q);
								depth_now  <= count_q;
								hash_ok    <= 1'b0;
								hash_value <= hash_q;
							end
						endcase
					end
				end
				S_INV_A: begin
					// t = base * x
					if (mul_done) begin
						mul_a_q  <= inv_q;
						mul_b_q  <= hgs_pkg::NEWTON_TWO - mul_p;
						mul_go_q <= 1'b1;
						state_q  <= S_INV_B;
					end
				end
				S_INV_B: begin
					// x = x * (2 - t)
					if (mul_done) begin
						inv_q <= mul_p;
						if (step_q == 3'(hgs_pkg::NEWTON_STEPS - 1)) begin
							state_q <= S_IDLE;
						end else begin
							step_q   <= step_q + 3'd1;
							mul_a_q  <= base_q;
							mul_b_q  <= mul_p;
							mul_go_q <= 1'b1;
							state_q  <= S_INV_A;
						end
					end
				end
				S_PUSH: begin
					if (mul_done) begin
						hash_q     <= mul_p + 64'(val_q);
						count_q    <= count_q + CW'(1);
						top_q      <= val_q;
						done       <= 1'b1;
						status     <= hgs_pkg::ST_OK;
						top_value  <= 32'(val_q);
						depth_now  <= count_q + CW'(1);
						hash_ok    <= 1'b0;
						hash_value <= mul_p + 64'(val_q);
					end
					if (mul_done)
						state_q <= S_IDLE;
				end
				S_POP: begin
					if (mul_done) begin
						hash_q     <= mul_p;
						count_q    <= count_q - CW'(1);
						top_q      <= (count_q >= CW'(2)) ? mem_rdata : '0;
						done       <= 1'b1;
						status     <= hgs_pkg::ST_OK;
						top_value  <= (count_q >= CW'(2)) ? 32'(mem_rdata) : 32'd0;
						depth_now  <= count_q - CW'(1);
						hash_ok    <= 1'b0;
						hash_value <= mul_p;
						state_q    <= S_IDLE;
					end
				end
				S_CHK_RD: begin
					if (idx_q == count_q) begin
						done       <= 1'b1;
						status     <= hgs_pkg::ST_OK;
						top_value  <= 32'(top_q);
						depth_now  <= count_q;
						hash_ok    <= (h_q == hash_q);
						hash_value <= hash_q;
						state_q    <= S_IDLE;
					end else begin
						state_q <= S_CHK_WAIT;
					end
				end
				S_CHK_WAIT: begin
					mul_a_q  <= h_q;
					mul_b_q  <= base_q;
					mul_go_q <= 1'b1;
					state_q  <= S_CHK_MUL;
				end
				S_CHK_MUL: begin
					if (mul_done) begin
						h_q     <= mul_p + 64'(mem_rdata);
						idx_q   <= idx_q + CW'(1);
						state_q <= S_CHK_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: hw/rtl/hgs_checker.sv
// Port-level checker for the hash guarded stack, bound to the top level.
module hgs_checker #(
	parameter int DEPTH = 1024,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input logic [1:0]    status,
	input logic [CW-1:0] depth_now,
	input logic          hash_ok
);

	// A result leaves the block idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");

	// An accepted transaction without an immediate result keeps the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done)) else $error("accepted transaction lost");

	// Full status only at full depth
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == hgs_pkg::ST_FULL) |-> (depth_now == CW'(DEPTH)))
		else $error("full reported below capacity");

	// Empty status only at zero depth and with hash_ok low
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == hgs_pkg::ST_EMPTY) |-> (depth_now == '0 && !hash_ok))
		else $error("empty reported with elements");

	// Depth never exceeds capacity
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (depth_now <= CW'(DEPTH))) else $error("depth beyond capacity");

endmodule

bind hash_guarded_stack hgs_checker #(.DEPTH(DEPTH)) u_hgs_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.status(status), .depth_now(depth_now), .hash_ok(hash_ok)
);

FILE: tb/hash_guarded_stack_tb.sv
// Testbench for the hash guarded stack: random and directed stack traffic checked against a predictor.
module hash_guarded_stack_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          STACK_DEPTH = 1024;
	localparam int          CYCLE_LIMIT = 4000000;
	localparam int          QUIET_FROM  = 300;
	localparam int          QUIET_TO    = 500;

	typedef struct {
		hgs_pkg::op_t op;
		logic [31:0]  value;
	} stack_cmd_t;

	typedef struct {
		hgs_pkg::status_t status;
		logic [31:0]      top_value;
		logic [10:0]      depth_now;
		logic             hash_ok;
		logic [63:0]      hash_value;
	} stack_reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  op = hgs_pkg::OP_NONE;
	logic [31:0] push_value = '0;
	logic        cfg_we = 1'b0;
	logic [63:0] cfg_data = '0;
	logic        done;
	logic [1:0]  status;
	logic [31:0] top_value;
	logic [10:0] depth_now;
	logic        hash_ok;
	logic [63:0] hash_value;

	hash_guarded_stack dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.push_value(push_value), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.done(done), .status(status), .top_value(top_value),
		.depth_now(depth_now), .hash_ok(hash_ok), .hash_value(hash_value)
	);

	always #5 clk = ~clk;

	// Predictor state
	logic [31:0]  stored [STACK_DEPTH];
	int           stored_count = 0;
	logic [63:0]  rolling_hash = '0;
	logic [63:0]  mult_base = 64'd1;
	logic [63:0]  mult_inverse = 64'd1;

	stack_cmd_t   pending_cmds [$];
	stack_reply_t expected_replies [$];
	int           issued = 0;
	int           accepted = 0;
	int           replies_seen = 0;
	int           mismatches = 0;
	int           cycles = 0;
	int           checks_done = 0;
	int           mismatch_checks = 0;
	int           full_hits = 0;
	int           empty_hits = 0;
	bit           hold_off = 1'b1;
	int           gen_depth = 0;

	function automatic logic [63:0] odd_base_inverse(logic [63:0] b);
		logic [63:0] x;
		x = 64'd1;
		for (int i = 0; i < 6; i++)
			x = x * (64'd2 - b * x);
		return x;
	endfunction

	// Apply one transaction to the predictor state and form its reply
	function automatic stack_reply_t stack_step(stack_cmd_t c);
		stack_reply_t r;
		logic [63:0]  h;
		r.status = hgs_pkg::ST_OK;
		r.hash_ok = 1'b0;
		case (c.op)
			hgs_pkg::OP_PUSH: begin
				if (stored_count >= STACK_DEPTH) begin
					r.status = hgs_pkg::ST_FULL;
				end else begin
					stored[stored_count] = c.value;
					rolling_hash = rolling_hash * mult_base + {32'd0, c.value};
					stored_count++;
				end
			end
			hgs_pkg::OP_POP: begin
				if (stored_count == 0) begin
					r.status = hgs_pkg::ST_EMPTY;
				end else begin
					rolling_hash = (rolling_hash - {32'd0, stored[stored_count - 1]})
						* mult_inverse;
					stored_count--;
				end
			end
			hgs_pkg::OP_CHECK: begin
				h = '0;
				for (int i = 0; i < stored_count; i++)
					h = h * mult_base + {32'd0, stored[i]};
				r.hash_ok = (h == rolling_hash);
			end
			default: ;
		endcase
		r.top_value = (stored_count > 0) ? stored[stored_count - 1] : 32'd0;
		r.depth_now = 11'(stored_count);
		r.hash_value = rolling_hash;
		return r;
	endfunction

	// Queue one command and track the depth it leads to
	task automatic add_cmd(hgs_pkg::op_t o, logic [31:0] v);
		stack_cmd_t c;
		c.op = o;
		c.value = v;
		pending_cmds.push_back(c);
		if (o == hgs_pkg::OP_PUSH && gen_depth < STACK_DEPTH)
			gen_depth++;
		else if (o == hgs_pkg::OP_POP && gen_depth > 0)
			gen_depth--;
	endtask

	// Random traffic: mostly pushes and pops, checks only while shallow
	task automatic add_random(int n);
		int pick;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 48)
				add_cmd(hgs_pkg::OP_PUSH, $urandom());
			else if (pick < 88)
				add_cmd(hgs_pkg::OP_POP, $urandom());
			else if (pick < 96 && gen_depth < 80)
				add_cmd(hgs_pkg::OP_CHECK, $urandom());
			else if (pick < 96)
				add_cmd(hgs_pkg::OP_POP, $urandom());
			else
				add_cmd(hgs_pkg::OP_NONE, $urandom());
		end
	endtask

	// Wait until the block has answered everything, then write the base
	task automatic write_base(logic [63:0] b);
		wait (pending_cmds.size() == 0 && issued == accepted
			&& expected_replies.size() == 0);
		hold_off = 1'b1;
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= b;
		mult_base = b | 64'd1;
		mult_inverse = odd_base_inverse(mult_base);
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_data <= $urandom() == 0 ? '1 : '0;
		repeat (2) @(negedge clk);
		while (busy)
			@(negedge clk);
		hold_off = 1'b0;
	endtask

	// Driver: hold a command until accepted, idle at random
	always @(negedge clk) begin
		stack_cmd_t c;
		if (arst_n) begin
			if (start && accepted != issued) begin
				// hold
			end else if (hold_off || pending_cmds.size() == 0 ||
				(!(issued >= QUIET_FROM && issued < QUIET_TO)
				&& $urandom_range(0, 99) < 9)) begin
				start <= 1'b0;
			end else begin
				c = pending_cmds.pop_front();
				start <= 1'b1;
				op <= c.op;
				push_value <= c.value;
				issued++;
			end
		end
	end

	// Monitor: compare replies, then predict newly accepted transactions
	always @(posedge clk) begin
		stack_reply_t e;
		stack_cmd_t   c;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Simulation FAILED");
			$finish;
		end else if (arst_n) begin
			if (done) begin
				replies_seen++;
				if (expected_replies.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: reply with nothing expected", $realtime);
				end else begin
					e = expected_replies.pop_front();
					if (status !== e.status || top_value !== e.top_value ||
						depth_now !== e.depth_now || hash_ok !== e.hash_ok ||
						hash_value !== e.hash_value) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: mismatch exp st=%0d top=%h dep=%0d ok=%b h=%h",
								$realtime, e.status, e.top_value, e.depth_now,
								e.hash_ok, e.hash_value);
							$display("    got st=%0d top=%h dep=%0d ok=%b h=%h",
								status, top_value, depth_now, hash_ok, hash_value);
						end
					end
				end
			end
			if (start && !busy && accepted != issued) begin
				c.op = hgs_pkg::op_t'(op);
				c.value = push_value;
				e = stack_step(c);
				if (c.op == hgs_pkg::OP_CHECK) begin
					checks_done++;
					if (!e.hash_ok)
						mismatch_checks++;
				end
				if (e.status == hgs_pkg::ST_FULL)
					full_hits++;
				if (e.status == hgs_pkg::ST_EMPTY)
					empty_hits++;
				expected_replies.push_back(e);
				accepted++;
			end
		end
	end

	initial begin
		int tail;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty pop, unused op, check on empty, extreme values
		add_cmd(hgs_pkg::OP_POP, '0);
		add_cmd(hgs_pkg::OP_NONE, '1);
		add_cmd(hgs_pkg::OP_CHECK, '0);
		add_cmd(hgs_pkg::OP_PUSH, 32'h0000_0000);
		add_cmd(hgs_pkg::OP_PUSH, 32'hFFFF_FFFF);
		add_cmd(hgs_pkg::OP_PUSH, 32'h8000_0001);
		add_cmd(hgs_pkg::OP_CHECK, '1);
		add_cmd(hgs_pkg::OP_NONE, '0);
		add_cmd(hgs_pkg::OP_POP, '1);
		add_cmd(hgs_pkg::OP_POP, '0);
		add_cmd(hgs_pkg::OP_POP, '0);
		add_cmd(hgs_pkg::OP_POP, '0);
		hold_off = 1'b0;

		// Extreme and random bases, each with traffic
		write_base(64'hFFFF_FFFF_FFFF_FFFF);
		add_random(150);
		write_base(64'h8000_0000_0000_0000);
		add_random(150);
		add_cmd(hgs_pkg::OP_CHECK, '0);
		// Base changed under stored elements: running hash is kept
		write_base({$urandom(), $urandom()});
		add_cmd(hgs_pkg::OP_CHECK, '0);
		add_random(150);
		write_base(64'd0);
		add_random(150);
		write_base({$urandom(), $urandom()} & 64'hFFFF_FFFF_FFFF_FFFE);
		add_random(150);

		// Small base, short traffic, one check, then drain past empty
		write_base(64'd31);
		add_random(50);
		add_cmd(hgs_pkg::OP_CHECK, '0);
		while (gen_depth > 0)
			add_cmd(hgs_pkg::OP_POP, $urandom());
		add_cmd(hgs_pkg::OP_POP, '0);

		wait (pending_cmds.size() == 0 && issued == accepted
			&& expected_replies.size() == 0);
		tail = 0;
		while (tail < 50) begin
			@(negedge clk);
			tail++;
		end
		$display("Covered %0d transactions, %0d checks (%0d hash mismatches reported),",
			accepted, checks_done, mismatch_checks);
		$display("%0d full pushes, %0d empty pops over six base settings",
			full_hits, empty_hits);
		if (mismatches == 0 && expected_replies.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/hgs_pkg.sv
hw/rtl/hgs_mul64.sv
hw/rtl/hgs_store.sv
hw/rtl/hash_guarded_stack.sv
hw/rtl/hgs_checker.sv
tb/hash_guarded_stack_tb.sv
